>>> hw/rtl/hfps_pkg.sv
// hfps_pkg: shared constants, codes and payload types of the heap file page store.
// Used by hfps_ctrl and heap_file_page_store; no dependencies.
package hfps_pkg;

	localparam int MAX_PAGES = 32;
	localparam int MAX_SLOTS = 64;
	localparam int KEY_BITS  = 32;

	localparam int PAGE_AW = $clog2(MAX_PAGES);
	localparam int SLOT_AW = $clog2(MAX_SLOTS);
	localparam int KEY_AW  = PAGE_AW + SLOT_AW;
	localparam int PG_CW   = $clog2(MAX_PAGES + 1);
	localparam int SL_CW   = $clog2(MAX_SLOTS + 1);
	localparam int NEED_W  = 17;

	localparam logic [15:0] HDR_BYTES      = 16'd16;
	localparam logic [15:0] REC_OVERHEAD   = 16'd4;
	localparam logic [15:0] PAGE_BYTES_RST = 16'd4096;

	localparam int          CFG_ADDR_W         = 3;
	localparam logic        CFG_IDX_PAGE_BYTES = 1'b0;

	typedef enum logic [1:0] {
		FUNC_INSERT  = 2'd0,
		FUNC_DISPLAY = 2'd1,
		FUNC_SEARCH  = 2'd2
	} func_e;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_ENTRY  = 2'd2,
		KIND_SEARCH = 2'd3
	} kind_e;

	typedef enum logic [1:0] {
		ST_STORED     = 2'd0,
		ST_TOO_LARGE  = 2'd1,
		ST_NO_PAGE    = 2'd2,
		ST_SLOTS_FULL = 2'd3
	} status_e;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_PRD,
		S_INS_PCHK,
		S_DISP_HDR,
		S_DISP_PRD,
		S_DISP_PCHK,
		S_SRCH_PRD,
		S_SRCH_PWAIT,
		S_SRCH_KEYS,
		S_EMIT
	} state_e;

	typedef struct packed {
		logic [1:0]         func;
		logic [15:0]        payload_len;
		logic signed [31:0] record_key;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] status;
		logic       found;
		logic [4:0] page_index;
		logic [5:0] slot_index;
		logic [6:0] count;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic [15:0] free;
		logic [6:0]  recs;
	} page_ent_t;

	localparam int PAGE_W = $bits(page_ent_t);

endpackage

>>> hw/rtl/hfps_ram.sv
// hfps_ram: simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
module hfps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/hfps_ctrl.sv
// hfps_ctrl: sequencer for insert, display and search over the page table and key RAMs,
// with the result holding register. Depends on hfps_pkg and hfps_ram.
module hfps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   page_bytes,
	input  logic          req_valid,
	output logic          req_ready,
	input  hfps_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hfps_pkg::rsp_t rsp_data
);
	import hfps_pkg::*;

	state_e state_q, state_d;

	logic [PG_CW-1:0]    pages_q, pg_q;
	logic [SL_CW-1:0]    slot_q, cnt_q;
	logic [SLOT_AW-1:0]  slot_s1;
	logic                key_vld_s1;
	logic [NEED_W-1:0]   need_q;
	logic [KEY_BITS-1:0] key_q;
	logic                blocked_q, more_q;
	rsp_t                res_q, res_d, out_q;
	logic                res_load, out_valid_q;

	logic                page_we;
	logic [PAGE_AW-1:0]  page_waddr, page_raddr;
	page_ent_t           page_wdata, page_rd;
	logic [PAGE_W-1:0]   page_rdata;
	logic                key_we;
	logic [KEY_AW-1:0]   key_waddr, key_raddr;
	logic [KEY_BITS-1:0] key_wdata, key_rdata;

	logic [15:0] cap;
	logic        accept, out_free, fits, slot_ok, scan_more, too_big, pages_full;
	logic        key_hit, slot_more, open_page, last_entry;

	hfps_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_page_ram (
		.clk   (clk),
		.we    (page_we),
		.waddr (page_waddr),
		.wdata (page_wdata),
		.raddr (page_raddr),
		.rdata (page_rdata)
	);

	hfps_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_PAGES * MAX_SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	assign page_raddr = pg_q[PAGE_AW-1:0];
	assign key_raddr  = {pg_q[PAGE_AW-1:0], slot_q[SLOT_AW-1:0]};
	assign page_rd    = page_ent_t'(page_rdata);

	assign cap        = (page_bytes > HDR_BYTES) ? page_bytes - HDR_BYTES : '0;
	assign accept     = req_valid && req_ready;
	assign out_free   = !out_valid_q || rsp_ready;
	assign fits       = {1'b0, page_rd.free} > need_q;
	assign slot_ok    = page_rd.recs < 7'(MAX_SLOTS);
	assign scan_more  = pg_q < pages_q;
	assign too_big    = {1'b0, cap} <= need_q;
	assign pages_full = pages_q >= PG_CW'(MAX_PAGES);
	assign key_hit    = key_vld_s1 && (key_rdata == key_q);
	assign slot_more  = slot_q < cnt_q;
	assign open_page  = (state_q == S_INS_PRD) && !scan_more && !too_big && !pages_full;
	assign last_entry = (pg_q + PG_CW'(1)) == pages_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (req_data.func)
						FUNC_INSERT:  state_d = S_INS_PRD;
						FUNC_DISPLAY: state_d = S_DISP_HDR;
						FUNC_SEARCH:  state_d = S_SRCH_PRD;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_INS_PRD:    state_d = scan_more ? S_INS_PCHK : S_EMIT;
			S_INS_PCHK:   state_d = (fits && slot_ok) ? S_EMIT : S_INS_PRD;
			S_DISP_HDR:   state_d = S_EMIT;
			S_DISP_PRD:   state_d = S_DISP_PCHK;
			S_DISP_PCHK:  state_d = S_EMIT;
			S_SRCH_PRD:   state_d = scan_more ? S_SRCH_PWAIT : S_EMIT;
			S_SRCH_PWAIT: state_d = S_SRCH_KEYS;
			S_SRCH_KEYS: begin
				if (key_hit) begin
					state_d = S_EMIT;
				end else if (!slot_more) begin
					state_d = S_SRCH_PRD;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = more_q ? S_DISP_PRD : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		page_we    = 1'b0;
		page_waddr = pg_q[PAGE_AW-1:0];
		page_wdata = '0;
		key_we     = 1'b0;
		key_waddr  = {pg_q[PAGE_AW-1:0], slot_q[SLOT_AW-1:0]};
		key_wdata  = key_q;
		res_d      = '0;
		res_d.last = 1'b1;
		res_load   = 1'b0;
		unique case (state_q)
			S_INS_PRD: begin
				if (!scan_more) begin
					res_load     = 1'b1;
					res_d.kind   = KIND_INSERT;
					if (too_big) begin
						res_d.status = ST_TOO_LARGE;
					end else if (pages_full) begin
						res_d.status = blocked_q ? ST_SLOTS_FULL : ST_NO_PAGE;
					end else begin
						res_d.status     = ST_STORED;
						res_d.page_index = pages_q[PAGE_AW-1:0];
						page_we          = 1'b1;
						page_waddr       = pages_q[PAGE_AW-1:0];
						page_wdata.free  = cap - need_q[15:0];
						page_wdata.recs  = 7'd1;
						key_we           = 1'b1;
						key_waddr        = {pages_q[PAGE_AW-1:0], SLOT_AW'(0)};
					end
				end
			end
			S_INS_PCHK: begin
				if (fits && slot_ok) begin
					res_load         = 1'b1;
					res_d.kind       = KIND_INSERT;
					res_d.status     = ST_STORED;
					res_d.page_index = pg_q[PAGE_AW-1:0];
					res_d.slot_index = page_rd.recs[SLOT_AW-1:0];
					page_we          = 1'b1;
					page_wdata.free  = page_rd.free - need_q[15:0];
					page_wdata.recs  = page_rd.recs + 7'd1;
					key_we           = 1'b1;
					key_waddr        = {pg_q[PAGE_AW-1:0], page_rd.recs[SLOT_AW-1:0]};
				end
			end
			S_DISP_HDR: begin
				res_load    = 1'b1;
				res_d.kind  = KIND_HEADER;
				res_d.count = 7'(pages_q);
				res_d.last  = (pages_q == '0);
			end
			S_DISP_PCHK: begin
				res_load         = 1'b1;
				res_d.kind       = KIND_ENTRY;
				res_d.page_index = pg_q[PAGE_AW-1:0];
				res_d.count      = page_rd.recs;
				res_d.last       = last_entry;
			end
			S_SRCH_PRD: begin
				if (!scan_more) begin
					res_load   = 1'b1;
					res_d.kind = KIND_SEARCH;
				end
			end
			S_SRCH_KEYS: begin
				if (key_hit) begin
					res_load         = 1'b1;
					res_d.kind       = KIND_SEARCH;
					res_d.found      = 1'b1;
					res_d.page_index = pg_q[PAGE_AW-1:0];
					res_d.slot_index = slot_s1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pages_q     <= '0;
			out_valid_q <= 1'b0;
			key_vld_s1  <= 1'b0;
			more_q      <= 1'b0;
			blocked_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			key_vld_s1 <= (state_q == S_SRCH_KEYS) && !key_hit && slot_more;
			if (open_page) begin
				pages_q <= pages_q + PG_CW'(1);
			end
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				more_q    <= 1'b0;
				blocked_q <= 1'b0;
			end else if (state_q == S_DISP_HDR) begin
				more_q <= (pages_q != '0);
			end else if (state_q == S_DISP_PCHK) begin
				more_q <= !last_entry;
			end else if (state_q == S_INS_PCHK && fits && !slot_ok) begin
				blocked_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			need_q <= NEED_W'(req_data.payload_len) + NEED_W'(REC_OVERHEAD);
			key_q  <= req_data.record_key;
			pg_q   <= '0;
		end
		case (state_q)
			S_INS_PCHK: begin
				if (!(fits && slot_ok)) begin
					pg_q <= pg_q + PG_CW'(1);
				end
			end
			S_DISP_PCHK: pg_q <= pg_q + PG_CW'(1);
			S_SRCH_PWAIT: begin
				cnt_q  <= page_rd.recs;
				slot_q <= '0;
			end
			S_SRCH_KEYS: begin
				if (!key_hit) begin
					if (slot_more) begin
						slot_s1 <= slot_q[SLOT_AW-1:0];
						slot_q  <= slot_q + SL_CW'(1);
					end else begin
						pg_q <= pg_q + PG_CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == S_EMIT && out_free) begin
			out_q <= res_q;
		end
	end
endmodule

>>> hw/rtl/heap_file_page_store.sv
// heap_file_page_store: top level with the configuration register port.
// Depends on hfps_pkg and hfps_ctrl.
//
// Requests come in on req_valid/req_ready/req_data (func, payload_len, record_key);
// results leave on rsp_valid/rsp_ready/rsp_data, the final result of a request
// flagged by last. Insert and search give one result, display gives a header and
// then one entry per open page. An unused func code is taken and gives no result.
// One request is worked at a time; req_ready is high while the sequencer is idle.
// Steps from acceptance to a result:
//   insert  reads and checks each open page in turn (page table RAM read, then
//           check), storing in the first that fits, else in a new open page,
//   display gives the header, then per open page a read, a check and a hand over,
//   search  reads each page table entry, then its keys (one key RAM read per
//           cycle; worst case all 2048 keys).
// Results wait in an output register; a new request is taken while it waits.
// When rsp_ready is low the sequencer holds its next result until the register
// frees. Reset empties the page store and sets page_bytes to 4096; the RAMs are
// not cleared, since only written entries are ever read. page_bytes sits at
// byte address 0 of the APB port and should be written only while idle.
module heap_file_page_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hfps_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  hfps_pkg::req_t                    req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output hfps_pkg::rsp_t                    rsp_data
);
	import hfps_pkg::*;

	logic [15:0] page_bytes_q;
	logic        cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = (paddr[CFG_ADDR_W-1:2] == CFG_IDX_PAGE_BYTES);
	assign prdata  = cfg_sel ? {16'd0, page_bytes_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_q <= PAGE_BYTES_RST;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			page_bytes_q <= pwdata[15:0];
		end
	end

	hfps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.page_bytes (page_bytes_q),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_data   (rsp_data)
	);
endmodule
